>>> rtl/fes_pkg.sv
package fes_pkg;

	localparam int HEAT_W  = 6;
	localparam int COLOR_W = 8;
	localparam int POS_W   = 18;
	localparam int CHOICE_W = 2;

	localparam logic [HEAT_W-1:0] MAX_HEAT = 6'd36;

	typedef enum logic {
		ACT_SPREAD = 1'b0,
		ACT_READ   = 1'b1
	} action_t;

	// outcome of one item, handed from the datapath to the control
	typedef struct packed {
		logic [HEAT_W-1:0]  heat;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               rejected;
		logic               write_en;
	} spread_res_t;

	// fire palette, indexed by heat, clamped at the hottest entry
	function automatic logic [3*COLOR_W-1:0] palette(input logic [HEAT_W-1:0] h);
		logic [3*COLOR_W-1:0] c;
		case (h)
			6'd0:    c = 24'h070707;
			6'd1:    c = 24'h1F0707;
			6'd2:    c = 24'h2F0F07;
			6'd3:    c = 24'h470F07;
			6'd4:    c = 24'h571707;
			6'd5:    c = 24'h671F07;
			6'd6:    c = 24'h771F07;
			6'd7:    c = 24'h8F2707;
			6'd8:    c = 24'h9F2F07;
			6'd9:    c = 24'hAF3F07;
			6'd10:   c = 24'hBF4707;
			6'd11:   c = 24'hC74707;
			6'd12:   c = 24'hDF4F07;
			6'd13:   c = 24'hDF5707;
			6'd14:   c = 24'hDF5707;
			6'd15:   c = 24'hD75F07;
			6'd16:   c = 24'hD75F07;
			6'd17:   c = 24'hD7670F;
			6'd18:   c = 24'hCF6F0F;
			6'd19:   c = 24'hCF770F;
			6'd20:   c = 24'hCF7F0F;
			6'd21:   c = 24'hCF8717;
			6'd22:   c = 24'hC78717;
			6'd23:   c = 24'hC78F17;
			6'd24:   c = 24'hC7971F;
			6'd25:   c = 24'hBF9F1F;
			6'd26:   c = 24'hBF9F1F;
			6'd27:   c = 24'hBFA727;
			6'd28:   c = 24'hBFA727;
			6'd29:   c = 24'hBFAF2F;
			6'd30:   c = 24'hB7AF2F;
			6'd31:   c = 24'hB7B72F;
			6'd32:   c = 24'hB7B737;
			6'd33:   c = 24'hCFCF6F;
			6'd34:   c = 24'hDFDF9F;
			6'd35:   c = 24'hEFEFC7;
			default: c = 24'hFFFFFF;
		endcase
		return c;
	endfunction

endpackage

>>> rtl/fes_ram.sv
module fes_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

>>> rtl/fes_datapath.sv
module fes_datapath import fes_pkg::*; #(
	parameter int FRAME_WIDTH = 640,
	parameter int PIXELS      = 245760
) (
	input  logic                      action,
	input  logic [POS_W-1:0]          position,
	input  logic [CHOICE_W-1:0]       rand_choice,
	input  logic [HEAT_W-1:0]         src_heat,
	output spread_res_t               res,
	output logic [$clog2(PIXELS)-1:0] waddr
);

	localparam int AW = $clog2(PIXELS);
	localparam int CW = ((AW > POS_W) ? AW : POS_W) + 2;

	logic [CW-1:0]        pos_ext;
	logic [CW-1:0]        base;
	logic [CW-1:0]        sub;
	logic [CW-1:0]        dst;
	logic                 out_of_range;
	logic                 top_row;
	logic [3*COLOR_W-1:0] rgb;

	assign pos_ext      = CW'(position);
	assign out_of_range = pos_ext >= CW'(PIXELS);
	assign top_row      = pos_ext < CW'(FRAME_WIDTH);
	assign rgb          = palette(src_heat);

	always_comb begin
		res      = '0;
		base     = pos_ext + CW'(1);
		sub      = CW'(rand_choice) + CW'(FRAME_WIDTH);
		dst      = '0;
		if (out_of_range) begin
			res.rejected = 1'b1;
		end else if (action == ACT_READ) begin
			res.heat  = src_heat;
			res.red   = rgb[3*COLOR_W-1:2*COLOR_W];
			res.green = rgb[2*COLOR_W-1:COLOR_W];
			res.blue  = rgb[COLOR_W-1:0];
		end else if (top_row) begin
			res.rejected = 1'b1;
		end else if (src_heat == '0) begin
			// cold source: plain copy one row up
			dst          = pos_ext - CW'(FRAME_WIDTH);
			res.write_en = 1'b1;
		end else if (base < sub) begin
			res.rejected = 1'b1;
		end else begin
			dst          = base - sub;
			res.heat     = src_heat - HEAT_W'(rand_choice[0]);
			res.write_en = 1'b1;
		end
		waddr = dst[AW-1:0];
	end

endmodule

>>> rtl/fire_effect_spread_unit.sv
// fire effect heat spreading unit
// holds a FRAME_WIDTH x FRAME_HEIGHT heat store (0..36) in one single-port ram.
// input channel (in_valid/in_ready) carries action, position, rand_choice:
//   spread copies the source heat one row up with jitter and decay,
//   read returns the stored heat and its palette color.
// output channel (out_valid/out_ready) carries heat, red, green, blue, rejected,
// one word per input word, in order.
// a word accepted in idle has its source heat read from the ram, and its result
// enters the output register from the response state once that register is free or drains.
// no new word is taken until the last one leaves the response state; the ram port
// serves the source read in the accept cycle and the target write in that state.
// after reset the unit sweeps the store, one pixel a cycle, over all
// FRAME_WIDTH*FRAME_HEIGHT pixels (245760 at the defaults), writing zero and
// 36 on the bottom row; in_ready stays low during the sweep.
// the next word is taken while a result waits in the output register; a
// stalled receiver holds the unit in its write cycle until the result moves.
module fire_effect_spread_unit import fes_pkg::*; #(
	parameter int FRAME_WIDTH  = 640,
	parameter int FRAME_HEIGHT = 384
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                action,
	input  logic [POS_W-1:0]    position,
	input  logic [CHOICE_W-1:0] rand_choice,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [HEAT_W-1:0]   heat,
	output logic [COLOR_W-1:0]  red,
	output logic [COLOR_W-1:0]  green,
	output logic [COLOR_W-1:0]  blue,
	output logic                rejected
);

	localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int AW     = $clog2(PIXELS);
	localparam int CW     = ((AW > POS_W) ? AW : POS_W) + 2;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_RESP  = 3'b100
	} state_t;

	state_t               state_q;
	logic [AW-1:0]        clr_cnt_q;
	logic                 out_valid_q;
	logic                 action_q;
	logic [POS_W-1:0]     position_q;
	logic [CHOICE_W-1:0]  choice_q;
	logic [HEAT_W-1:0]    heat_q;
	logic [COLOR_W-1:0]   red_q;
	logic [COLOR_W-1:0]   green_q;
	logic [COLOR_W-1:0]   blue_q;
	logic                 rejected_q;

	logic                 accept;
	logic                 out_free;
	logic                 ram_en;
	logic                 ram_we;
	logic [AW-1:0]        ram_addr;
	logic [HEAT_W-1:0]    ram_wdata;
	logic [HEAT_W-1:0]    ram_rdata;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        waddr;
	spread_res_t          res;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign heat      = heat_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;
	assign rejected  = rejected_q;

	// out of frame positions read a harmless address, the result is rejected anyway
	assign rd_addr = (CW'(position) < CW'(PIXELS)) ? AW'(position) : '0;

	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = rd_addr;
		ram_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = clr_cnt_q;
				ram_wdata = (clr_cnt_q >= AW'(PIXELS - FRAME_WIDTH)) ? MAX_HEAT : '0;
			end
			ST_IDLE: begin
				ram_en = accept;
			end
			ST_RESP: begin
				ram_en    = out_free && res.write_en;
				ram_we    = 1'b1;
				ram_addr  = waddr;
				ram_wdata = res.heat;
			end
			default: begin
				ram_en = 1'b0;
			end
		endcase
	end

	fes_ram #(
		.WIDTH(HEAT_W),
		.DEPTH(PIXELS)
	) u_heat_store (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	fes_datapath #(
		.FRAME_WIDTH(FRAME_WIDTH),
		.PIXELS     (PIXELS)
	) u_datapath (
		.action      (action_q),
		.position    (position_q),
		.rand_choice (choice_q),
		.src_heat    (ram_rdata),
		.res         (res),
		.waddr       (waddr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(PIXELS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q   <= action;
			position_q <= position;
			choice_q   <= rand_choice;
		end
		if (state_q == ST_RESP && out_free) begin
			heat_q     <= res.heat;
			red_q      <= res.red;
			green_q    <= res.green;
			blue_q     <= res.blue;
			rejected_q <= res.rejected;
		end
	end

endmodule

>>> bench/fire_bench_pkg.sv
package fire_bench_pkg;
	import fes_pkg::*;

	localparam int FRAME_W = 640;
	localparam int FRAME_H = 384;
	localparam int PIXELS  = FRAME_W * FRAME_H;

	// fire colors by heat, red in the top byte
	localparam logic [3*COLOR_W-1:0] FIRE_COLORS [37] = '{
		24'h070707, 24'h1F0707, 24'h2F0F07, 24'h470F07, 24'h571707, 24'h671F07,
		24'h771F07, 24'h8F2707, 24'h9F2F07, 24'hAF3F07, 24'hBF4707, 24'hC74707,
		24'hDF4F07, 24'hDF5707, 24'hDF5707, 24'hD75F07, 24'hD75F07, 24'hD7670F,
		24'hCF6F0F, 24'hCF770F, 24'hCF7F0F, 24'hCF8717, 24'hC78717, 24'hC78F17,
		24'hC7971F, 24'hBF9F1F, 24'hBF9F1F, 24'hBFA727, 24'hBFA727, 24'hBFAF2F,
		24'hB7AF2F, 24'hB7B72F, 24'hB7B737, 24'hCFCF6F, 24'hDFDF9F, 24'hEFEFC7,
		24'hFFFFFF
	};

	typedef struct packed {
		logic [HEAT_W-1:0]  heat;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               rejected;
	} fire_word_t;

	class heat_scoreboard;
		logic [HEAT_W-1:0] heat_map [PIXELS];
		fire_word_t        expected_words [$];
		int                n_errors   = 0;
		int                n_checked  = 0;
		int                n_spreads  = 0;
		int                n_reads    = 0;
		int                n_rejected = 0;

		function new();
			for (int i = 0; i < PIXELS; i++)
				heat_map[i] = (i >= PIXELS - FRAME_W) ? MAX_HEAT : '0;
		endfunction

		// updates the heat map for one accepted word and queues the word it should produce
		function void apply_word(action_t act, logic [POS_W-1:0] pos,
				logic [CHOICE_W-1:0] choice);
			fire_word_t        w;
			int unsigned       s;
			logic [HEAT_W-1:0] h;
			w = '0;
			s = pos;
			if (act == ACT_READ)
				n_reads++;
			else
				n_spreads++;
			if (s >= PIXELS) begin
				w.rejected = 1'b1;
			end else if (act == ACT_READ) begin
				h = heat_map[s];
				w.heat = h;
				{w.red, w.green, w.blue} = FIRE_COLORS[(h > MAX_HEAT) ? MAX_HEAT : h];
			end else if (s < FRAME_W) begin
				w.rejected = 1'b1;
			end else begin
				h = heat_map[s];
				if (h == '0) begin
					heat_map[s - FRAME_W] = '0;
				end else if (s + 1 < choice + FRAME_W) begin
					// target would fall below address zero
					w.rejected = 1'b1;
				end else begin
					w.heat = h - choice[0];
					heat_map[s + 1 - choice - FRAME_W] = w.heat;
				end
			end
			if (w.rejected)
				n_rejected++;
			expected_words.push_back(w);
		endfunction

		// where a spread from s lands, -1 when nothing gets written
		function int next_source(int unsigned s, logic [CHOICE_W-1:0] choice);
			if (s < FRAME_W || s >= PIXELS)
				return -1;
			if (heat_map[s] == '0)
				return s - FRAME_W;
			if (s + 1 < choice + FRAME_W)
				return -1;
			return s + 1 - choice - FRAME_W;
		endfunction

		task report_mismatch(string msg);
			n_errors++;
			if (n_errors <= 100)
				$display("mismatch: %s", msg);
		endtask

		task check_word(fire_word_t got);
			fire_word_t want;
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("word with nothing pending, heat %0d rejected %0b",
					got.heat, got.rejected));
				return;
			end
			want = expected_words.pop_front();
			if (got.heat !== want.heat)
				report_mismatch($sformatf("word %0d heat got %0d want %0d",
					n_checked, got.heat, want.heat));
			if (got.red !== want.red)
				report_mismatch($sformatf("word %0d red got %h want %h",
					n_checked, got.red, want.red));
			if (got.green !== want.green)
				report_mismatch($sformatf("word %0d green got %h want %h",
					n_checked, got.green, want.green));
			if (got.blue !== want.blue)
				report_mismatch($sformatf("word %0d blue got %h want %h",
					n_checked, got.blue, want.blue));
			if (got.rejected !== want.rejected)
				report_mismatch($sformatf("word %0d rejected got %b want %b",
					n_checked, got.rejected, want.rejected));
			n_checked++;
		endtask
	endclass

endpackage

>>> bench/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fes_pkg::*;
	import fire_bench_pkg::*;

	localparam int WORDS_TOTAL = 850;
	localparam int BOT         = (FRAME_H - 1) * FRAME_W;
	localparam int LAST        = PIXELS - 1;
	localparam int POS_MAX     = 2**POS_W - 1;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                in_valid    = 1'b0;
	logic                in_ready;
	logic                action      = 1'b0;
	logic [POS_W-1:0]    position    = '0;
	logic [CHOICE_W-1:0] rand_choice = '0;
	logic                out_valid;
	logic                out_ready   = 1'b0;
	logic [HEAT_W-1:0]   heat;
	logic [COLOR_W-1:0]  red;
	logic [COLOR_W-1:0]  green;
	logic [COLOR_W-1:0]  blue;
	logic                rejected;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int words_sent  = 0;

	heat_scoreboard sb;

	fire_effect_spread_unit #(
		.FRAME_WIDTH (FRAME_W),
		.FRAME_HEIGHT(FRAME_H)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.position   (position),
		.rand_choice(rand_choice),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.heat       (heat),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.rejected   (rejected)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_word({heat, red, green, blue, rejected});
	end

	task automatic send_word(action_t act, int unsigned pos, logic [CHOICE_W-1:0] choice);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < tx_idle_pct && gap < 12)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		position    <= pos[POS_W-1:0];
		rand_choice <= choice;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.apply_word(act, pos[POS_W-1:0], choice);
		words_sent++;
	endtask

	// follow the heat upward from one pixel, reading back some of the targets
	task automatic climb(int unsigned start, int steps, bit straight);
		int unsigned         s;
		int                  nxt;
		logic [CHOICE_W-1:0] c;
		s = start;
		for (int k = 0; k < steps; k++) begin
			// alternating 0 and 2 climbs a column with no decay
			c = straight ? ((k % 2) ? 2'd2 : 2'd0) : CHOICE_W'($urandom_range(0, 3));
			nxt = sb.next_source(s, c);
			send_word(ACT_SPREAD, s, c);
			if (nxt < 0)
				break;
			if (!straight && $urandom_range(0, 3) == 0)
				send_word(ACT_READ, nxt, CHOICE_W'($urandom_range(0, 3)));
			s = nxt;
		end
	endtask

	initial begin
		int          guard;
		int unsigned pick;
		int unsigned row;
		sb = new();
		tx_idle_pct = 15;
		rx_idle_pct = 48;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		send_word(ACT_READ, 0, 2'd0);
		send_word(ACT_READ, LAST, 2'd3);
		send_word(ACT_READ, PIXELS, 2'd1);
		send_word(ACT_READ, POS_MAX, 2'd3);
		send_word(ACT_SPREAD, 0, 2'd0);
		send_word(ACT_SPREAD, FRAME_W - 1, 2'd2);
		send_word(ACT_SPREAD, PIXELS, 2'd1);
		send_word(ACT_SPREAD, POS_MAX, 2'd3);
		send_word(ACT_SPREAD, BOT, 2'd0);
		send_word(ACT_SPREAD, BOT, 2'd1);
		// spills into the last pixel of the row two above
		send_word(ACT_SPREAD, BOT, 2'd2);
		// lands back on the bottom row
		send_word(ACT_SPREAD, LAST, 2'd0);
		send_word(ACT_SPREAD, LAST, 2'd3);
		send_word(ACT_READ, BOT - FRAME_W, 2'd0);
		send_word(ACT_READ, BOT - 1 - FRAME_W, 2'd2);
		send_word(ACT_SPREAD, BOT - FRAME_W, 2'd3);
		send_word(ACT_READ, BOT - 2 * FRAME_W - 2, 2'd1);
		// cold source clears the pixel above
		send_word(ACT_SPREAD, 10 * FRAME_W + 5, 2'd2);
		send_word(ACT_READ, 9 * FRAME_W + 5, 2'd1);

		for (int ph = 0; ph < 3; ph++) begin
			tx_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 48 : 0;
			rx_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 15 : 0;
			if (ph == 0) begin
				// carry full heat up column 0 to row 1, then spread off the low edge
				climb(BOT, FRAME_H - 2, 1'b1);
				send_word(ACT_SPREAD, FRAME_W, 2'd2);
				send_word(ACT_SPREAD, FRAME_W, 2'd3);
				send_word(ACT_SPREAD, FRAME_W, 2'd1);
				send_word(ACT_READ, 0, 2'd0);
			end
			while (words_sent < WORDS_TOTAL * (ph + 1) / 3) begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					row = ($urandom_range(0, 9) < 7) ? FRAME_H - 1
						: $urandom_range(FRAME_H - 40, FRAME_H - 1);
					climb(row * FRAME_W + $urandom_range(0, FRAME_W - 1),
						$urandom_range(3, 30), 1'b0);
				end else if (pick < 75) begin
					send_word(ACT_READ, $urandom_range(PIXELS - 48 * FRAME_W, LAST),
						CHOICE_W'($urandom_range(0, 3)));
				end else if (pick < 82) begin
					// top row or beyond the frame
					send_word(ACT_SPREAD, $urandom_range(0, 1) ? $urandom_range(0, FRAME_W - 1)
						: $urandom_range(PIXELS, POS_MAX), CHOICE_W'($urandom_range(0, 3)));
				end else if (pick < 91) begin
					send_word(ACT_SPREAD, $urandom_range(0, POS_MAX),
						CHOICE_W'($urandom_range(0, 3)));
				end else begin
					send_word(ACT_READ, $urandom_range(0, POS_MAX),
						CHOICE_W'($urandom_range(0, 3)));
				end
			end
		end
		in_valid <= 1'b0;

		guard = 0;
		while (sb.expected_words.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
		if (sb.expected_words.size() != 0)
			sb.report_mismatch($sformatf("%0d words never came out", sb.expected_words.size()));

		$display("%0d words checked: %0d spreads, %0d reads, %0d rejected",
			sb.n_checked, sb.n_spreads, sb.n_reads, sb.n_rejected);
		$display("column 0 carried to row 1, three idle mixes on both channels");
		if (sb.n_errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// the store sweep after reset alone takes about half a millisecond
	initial begin
		#2000000;
		$display("timeout after %0d words sent", words_sent);
		$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> files.f
rtl/fes_pkg.sv
rtl/fes_ram.sv
rtl/fes_datapath.sv
rtl/fire_effect_spread_unit.sv
bench/fire_bench_pkg.sv
bench/tb_top.sv
